@@ rtl/region_select_bump_allocator_assert.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef REGION_SELECT_BUMP_ALLOCATOR_ASSERT_SVH
`define REGION_SELECT_BUMP_ALLOCATOR_ASSERT_SVH

// Checked at every clock edge outside reset.
`define RSBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define RSBA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ rtl/rsba_pkg.sv @@
// Package with widths, constants and codes of the region-select bump allocator.
package rsba_pkg;

    // Pool addresses are clamped to 2^ADDR_LIMIT_BITS.
    localparam int ADDR_LIMIT_BITS = 32;
    localparam int AW              = ADDR_LIMIT_BITS + 1;
    localparam int PW              = ((ADDR_LIMIT_BITS > 33) ? ADDR_LIMIT_BITS : 33) + 3;
    localparam int OUT_W           = 33;
    localparam int PAGE_SHIFT      = 12;

    typedef logic [AW-1:0] t_addr;
    typedef logic [PW-1:0] t_wide;

    localparam logic [63:0] ADDR_CAP      = 64'd1 << ADDR_LIMIT_BITS;
    localparam t_addr       LOW_FLOOR     = AW'(64'd1 << 20);
    localparam t_addr       PAGE_MASK     = AW'(64'hFFF);
    localparam logic [31:0] DEFAULT_ALIGN = 32'd16;

    // Usable firmware memory type codes.
    localparam logic [31:0] MT_LOADER_CODE  = 32'd1;
    localparam logic [31:0] MT_LOADER_DATA  = 32'd2;
    localparam logic [31:0] MT_BOOT_CODE    = 32'd3;
    localparam logic [31:0] MT_BOOT_DATA    = 32'd4;
    localparam logic [31:0] MT_CONVENTIONAL = 32'd7;
    localparam logic [31:0] MT_ACPI_RECLAIM = 32'd9;
    localparam logic [31:0] MT_ACPI_NVS     = 32'd10;

    typedef enum logic [1:0] {
        OP_DESCRIPTOR = 2'd0,
        OP_FINISH     = 2'd1,
        OP_ALLOCATE   = 2'd2
    } t_op;

endpackage

@@ rtl/region_select_bump_allocator.sv @@
// Top level of the region-select bump allocator: one two-register pipeline.
//
// The block takes one beat per item on the input channel (i_in_valid and
// o_in_stall) and returns exactly one result beat per item on the output
// channel (o_out_valid and i_out_stall), in order. A descriptor beat offers
// a memory region, a finish beat fixes the pool base at or above 1 MiB on a
// 4 KiB boundary, and an allocate beat bumps the pointer through the pool.
// Every result carries the grant flag, the block address, the pool limit and
// the highest usable end address seen so far.
//
// A beat accepted on the input channel is held in the input register,
// processed against the pool state from there, and its result is loaded
// into the result register, where the receiver can take it. Throughput is
// one beat per cycle while the receiver does not stall a result; the state
// update for one item is a single pass of adders and comparators, so a new
// item can follow directly behind the previous one.
//
// When the receiver stalls a valid result, the whole pipeline holds and
// o_in_stall is raised in the same cycle; nothing is dropped. A synchronous
// low reset clears the pool state and both valid flags; the first beat may
// be offered in the cycle after reset is released.
`include "region_select_bump_allocator_assert.svh"

module region_select_bump_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_mem_type,
    input  logic [63:0] i_phys_addr,
    input  logic [63:0] i_page_count,
    input  logic [32:0] i_alloc_size,
    input  logic [31:0] i_alignment,
    // Output channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_granted,
    output logic [32:0] o_block_addr,
    output logic [32:0] o_pool_limit,
    output logic [32:0] o_memory_top
);

    // Pipeline control: everything moves unless a result is held by the receiver.
    logic advance;

    // Input register.
    logic            r_in_valid;
    rsba_pkg::t_op   r_op;
    logic [1:0]      r_op_code;
    logic [31:0]     r_mem_type;
    logic [63:0]     r_phys_addr;
    logic [63:0]     r_page_count;
    logic [32:0]     r_alloc_size;
    logic [31:0]     r_alignment;

    // Pool state.
    rsba_pkg::t_addr r_region_start, n_region_start;
    rsba_pkg::t_addr r_region_limit, n_region_limit;
    rsba_pkg::t_addr r_next_free,    n_next_free;
    rsba_pkg::t_addr r_highest_end,  n_highest_end;

    // Result register.
    logic                       r_out_valid;
    logic                       r_granted,    n_granted;
    logic [rsba_pkg::AW-1:0]    r_block_addr, n_block_addr;

    // Descriptor path.
    logic [63:0]     d_stop_raw;
    logic [63:0]     d_stop64;
    logic            d_usable;
    logic            d_nonempty;
    rsba_pkg::t_addr d_start;
    rsba_pkg::t_addr d_stop;
    rsba_pkg::t_addr d_len;
    rsba_pkg::t_addr d_cur_len;
    logic            d_cur_ok;
    logic            d_wins;

    // Finish path.
    rsba_pkg::t_addr f_floor;
    rsba_pkg::t_addr f_base;

    // Allocate path.
    logic [31:0]     a_align;
    rsba_pkg::t_wide a_mask;
    rsba_pkg::t_wide a_addr;
    rsba_pkg::t_wide a_end;
    logic            a_fits;

    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_op_code    <= i_operation;
            r_mem_type   <= i_mem_type;
            r_phys_addr  <= i_phys_addr;
            r_page_count <= i_page_count;
            r_alloc_size <= i_alloc_size;
            r_alignment  <= i_alignment;
        end
    end

    assign r_op = rsba_pkg::t_op'(r_op_code);

    // Descriptor: end address wraps at 64 bits, then clamps to the address limit.
    assign d_stop_raw = r_phys_addr + {r_page_count[63-rsba_pkg::PAGE_SHIFT:0],
                                       {rsba_pkg::PAGE_SHIFT{1'b0}}};
    assign d_stop64   = (d_stop_raw > rsba_pkg::ADDR_CAP) ? rsba_pkg::ADDR_CAP : d_stop_raw;
    assign d_nonempty = r_phys_addr < d_stop64;
    assign d_usable   = (r_mem_type == rsba_pkg::MT_LOADER_CODE)  ||
                        (r_mem_type == rsba_pkg::MT_LOADER_DATA)  ||
                        (r_mem_type == rsba_pkg::MT_BOOT_CODE)    ||
                        (r_mem_type == rsba_pkg::MT_BOOT_DATA)    ||
                        (r_mem_type == rsba_pkg::MT_CONVENTIONAL) ||
                        (r_mem_type == rsba_pkg::MT_ACPI_RECLAIM) ||
                        (r_mem_type == rsba_pkg::MT_ACPI_NVS);
    // A non-empty region lies entirely below the cap, so both ends fit the pool width.
    assign d_start    = rsba_pkg::AW'(r_phys_addr);
    assign d_stop     = rsba_pkg::AW'(d_stop64);
    assign d_len      = d_stop - d_start;
    // When the base has been pushed past the limit, the current length would wrap,
    // so d_cur_ok is low and no region can beat it.
    assign d_cur_ok   = r_region_limit >= r_region_start;
    assign d_cur_len  = r_region_limit - r_region_start;
    assign d_wins     = d_cur_ok && (d_len > d_cur_len);

    // Finish: raise to 1 MiB, then round up to a page boundary.
    assign f_floor = (r_region_start < rsba_pkg::LOW_FLOOR) ? rsba_pkg::LOW_FLOOR
                                                            : r_region_start;
    assign f_base  = (f_floor + rsba_pkg::PAGE_MASK) & ~rsba_pkg::PAGE_MASK;

    // Allocate: align the pointer with the mask formula, then check the limit.
    assign a_align = (r_alignment == 32'd0) ? rsba_pkg::DEFAULT_ALIGN : r_alignment;
    assign a_mask  = rsba_pkg::PW'(a_align - 32'd1);
    assign a_addr  = (rsba_pkg::PW'(r_next_free) + a_mask) & ~a_mask;
    assign a_end   = a_addr + rsba_pkg::PW'(r_alloc_size);
    assign a_fits  = a_end <= rsba_pkg::PW'(r_region_limit);

    always_comb begin
        n_region_start = r_region_start;
        n_region_limit = r_region_limit;
        n_next_free    = r_next_free;
        n_highest_end  = r_highest_end;
        n_granted      = 1'b0;
        n_block_addr   = '0;
        case (r_op)
            rsba_pkg::OP_DESCRIPTOR: begin
                if (d_usable && d_nonempty) begin
                    if (d_stop > r_highest_end) begin
                        n_highest_end = d_stop;
                    end
                    if (d_wins) begin
                        n_region_start = d_start;
                        n_region_limit = d_stop;
                    end
                end
            end
            rsba_pkg::OP_FINISH: begin
                n_region_start = f_base;
                n_next_free    = f_base;
            end
            rsba_pkg::OP_ALLOCATE: begin
                if (a_fits) begin
                    n_granted    = 1'b1;
                    n_block_addr = rsba_pkg::AW'(a_addr);
                    n_next_free  = rsba_pkg::AW'(a_end);
                end
            end
            default: begin
                // Unused code: report the state unchanged.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_start <= '0;
            r_region_limit <= '0;
            r_next_free    <= '0;
            r_highest_end  <= '0;
            r_out_valid    <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_region_start <= n_region_start;
                r_region_limit <= n_region_limit;
                r_next_free    <= n_next_free;
                r_highest_end  <= n_highest_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_granted    <= n_granted;
            r_block_addr <= n_block_addr;
        end
    end

    // Pool limit and memory top only change when a result is loaded, so they
    // read straight from the state registers.
    assign o_out_valid  = r_out_valid;
    assign o_granted    = r_granted;
    assign o_block_addr = rsba_pkg::OUT_W'(r_block_addr);
    assign o_pool_limit = rsba_pkg::OUT_W'(r_region_limit);
    assign o_memory_top = rsba_pkg::OUT_W'(r_highest_end);

    `RSBA_ASSERT(a_grant_inside_pool,
        (r_out_valid && r_granted) |-> (r_block_addr <= r_region_limit),
        "granted block lies above the pool limit")
    `RSBA_ASSERT(a_refusal_has_no_addr,
        (r_out_valid && !r_granted) |-> (r_block_addr == '0),
        "refused or non-allocate result carries an address")
    `RSBA_ASSERT(a_top_covers_pool,
        r_highest_end >= r_region_limit,
        "memory top fell below the pool limit")
    `RSBA_ASSERT(a_pointer_below_cap,
        rsba_pkg::PW'(r_next_free) <= rsba_pkg::PW'(rsba_pkg::ADDR_CAP),
        "bump pointer passed the address limit")
    `RSBA_ASSERT_ALWAYS(a_reset_clears_valid,
        !i_rst_n |=> !r_out_valid && !r_in_valid,
        "pipeline holds a beat right after reset")

endmodule

@@ tb/region_select_bump_allocator_checker.sv @@
// Checker for the region-select bump allocator: watches both channels, predicts, compares.
`timescale 1ns / 100ps

module region_select_bump_allocator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_mem_type,
    input  logic [63:0] i_phys_addr,
    input  logic [63:0] i_page_count,
    input  logic [32:0] i_alloc_size,
    input  logic [31:0] i_alignment,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_granted,
    input  logic [32:0] i_block_addr,
    input  logic [32:0] i_pool_limit,
    input  logic [32:0] i_memory_top,
    output int          o_mismatches,
    output int          o_outstanding
);

    typedef struct packed {
        logic        granted;
        logic [32:0] block_addr;
        logic [32:0] pool_limit;
        logic [32:0] memory_top;
    } t_result;

    // Pool state, kept at 64 bits so that wrapping sums and differences behave
    // exactly as the allocator defines them.
    logic [63:0] pred_start;
    logic [63:0] pred_limit;
    logic [63:0] bump_ptr;
    logic [63:0] top_end;

    t_result pending_results[$];

    function automatic bit code_usable(input logic [31:0] code);
        case (code)
            rsba_pkg::MT_LOADER_CODE, rsba_pkg::MT_LOADER_DATA, rsba_pkg::MT_BOOT_CODE,
            rsba_pkg::MT_BOOT_DATA, rsba_pkg::MT_CONVENTIONAL, rsba_pkg::MT_ACPI_RECLAIM,
            rsba_pkg::MT_ACPI_NVS: code_usable = 1'b1;
            default: code_usable = 1'b0;
        endcase
    endfunction

    task automatic predict_pool(input logic [1:0] op, input logic [31:0] code,
                                input logic [63:0] start, input logic [63:0] pages,
                                input logic [32:0] size, input logic [31:0] align,
                                output t_result res);
        logic [63:0] stop;
        logic [63:0] align_bytes;
        logic [63:0] cand;
        res = '0;
        case (op)
            rsba_pkg::OP_DESCRIPTOR: begin
                if (code_usable(code)) begin
                    stop = start + (pages << rsba_pkg::PAGE_SHIFT);
                    if (stop > rsba_pkg::ADDR_CAP)
                        stop = rsba_pkg::ADDR_CAP;
                    if (start < stop) begin
                        if (stop > top_end)
                            top_end = stop;
                        // Only a strictly longer region replaces the pool.
                        if (stop - start > pred_limit - pred_start) begin
                            pred_start = start;
                            pred_limit = stop;
                        end
                    end
                end
            end
            rsba_pkg::OP_FINISH: begin
                if (pred_start < 64'(rsba_pkg::LOW_FLOOR))
                    pred_start = 64'(rsba_pkg::LOW_FLOOR);
                pred_start = (pred_start + 64'(rsba_pkg::PAGE_MASK))
                             & ~64'(rsba_pkg::PAGE_MASK);
                bump_ptr   = pred_start;
            end
            rsba_pkg::OP_ALLOCATE: begin
                align_bytes = (align == '0) ? 64'(rsba_pkg::DEFAULT_ALIGN) : 64'(align);
                cand = (bump_ptr + align_bytes - 64'd1) & ~(align_bytes - 64'd1);
                if (cand + 64'(size) <= pred_limit) begin
                    bump_ptr       = cand + 64'(size);
                    res.granted    = 1'b1;
                    res.block_addr = cand[32:0];
                end
            end
            default: ;
        endcase
        res.pool_limit = pred_limit[32:0];
        res.memory_top = top_end[32:0];
    endtask

    task automatic compare_field(input string field, input logic [32:0] want,
                                 input logic [32:0] got, inout int errs);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
            errs++;
        end
    endtask

    t_result fresh;
    t_result oldest;
    int      errs;

    always @(posedge i_clk) begin
        errs = 0;
        if (!i_rst_n) begin
            pred_start = '0;
            pred_limit = '0;
            bump_ptr   = '0;
            top_end    = '0;
            pending_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_pool(i_operation, i_mem_type, i_phys_addr, i_page_count,
                             i_alloc_size, i_alignment, fresh);
                pending_results.push_back(fresh);
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat expected none actual %h %h %h %h", $time,
                             i_granted, i_block_addr, i_pool_limit, i_memory_top);
                    errs++;
                end else begin
                    oldest = pending_results.pop_front();
                    compare_field("granted", 33'(oldest.granted), 33'(i_granted), errs);
                    compare_field("block_addr", oldest.block_addr, i_block_addr, errs);
                    compare_field("pool_limit", oldest.pool_limit, i_pool_limit, errs);
                    compare_field("memory_top", oldest.memory_top, i_memory_top, errs);
                end
            end
        end
        o_mismatches  <= (!i_rst_n) ? 0 : o_mismatches + errs;
        o_outstanding <= pending_results.size();
    end

endmodule

@@ tb/tb.sv @@
// Testbench top for the region-select bump allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;

    // Operation code 3 is not decoded by the block; it must come back as a
    // plain status beat with no grant.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Useful items to send in total, directed part included.
    localparam int ITEM_TARGET = 750;

    // The slowest correct run, even with both sides idling at their worst random
    // streaks, stays far inside this limit.
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_operation  = rsba_pkg::OP_DESCRIPTOR;
    logic [31:0] i_mem_type   = '0;
    logic [63:0] i_phys_addr  = '0;
    logic [63:0] i_page_count = '0;
    logic [32:0] i_alloc_size = '0;
    logic [31:0] i_alignment  = '0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic        o_granted;
    logic [32:0] o_block_addr;
    logic [32:0] o_pool_limit;
    logic [32:0] o_memory_top;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int sent_items  = 0;

    // While set, neither side idles: results stream back to back through the
    // two-stage pipeline for a while.
    logic quiet = 1'b0;

    region_select_bump_allocator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_mem_type   (i_mem_type),
        .i_phys_addr  (i_phys_addr),
        .i_page_count (i_page_count),
        .i_alloc_size (i_alloc_size),
        .i_alignment  (i_alignment),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_granted    (o_granted),
        .o_block_addr (o_block_addr),
        .o_pool_limit (o_pool_limit),
        .o_memory_top (o_memory_top)
    );

    region_select_bump_allocator_checker alloc_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_mem_type    (i_mem_type),
        .i_phys_addr   (i_phys_addr),
        .i_page_count  (i_page_count),
        .i_alloc_size  (i_alloc_size),
        .i_alignment   (i_alignment),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_granted     (o_granted),
        .i_block_addr  (o_block_addr),
        .i_pool_limit  (o_pool_limit),
        .i_memory_top  (o_memory_top),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** region_select_bump_allocator: FAILED **");
            $finish;
        end
    end

    // Result side: stall about 30 percent of the time, except in the quiet
    // stretch. The stall is random per cycle and never looks at valid.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < 30);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Sends one beat and returns at the edge where it is accepted. Idle
    // cycles come first, so gaps land before descriptors, finishes and
    // allocations alike. The stall is read at the falling edge, where it has
    // settled to the value the next rising edge samples.
    task automatic send_beat(input logic [1:0] op, input logic [31:0] code,
                             input logic [63:0] start, input logic [63:0] pages,
                             input logic [32:0] size, input logic [31:0] align);
        logic burst;
        logic stalled;
        burst = (sent_items >= 300) && (sent_items < 420);
        quiet <= burst;
        while (!burst && ($urandom_range(0, 99) < 30)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_mem_type   <= code;
        i_phys_addr  <= start;
        i_page_count <= pages;
        i_alloc_size <= size;
        i_alignment  <= align;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        if (op != OP_UNUSED)
            sent_items++;
    endtask

    // The fields an operation does not use still carry random bits, so the
    // block is seen to ignore them.
    task automatic post_descriptor(input logic [31:0] code, input logic [63:0] start,
                                   input logic [63:0] pages);
        send_beat(rsba_pkg::OP_DESCRIPTOR, code, start, pages,
                  {1'($urandom_range(0, 1)), 32'($urandom)} & 33'h1_0000_0000 | 33'($urandom),
                  $urandom_range(0, 32'h8000_0000));
    endtask

    task automatic post_finish();
        send_beat(rsba_pkg::OP_FINISH, $urandom, rand64(), rand64(), 33'($urandom), $urandom);
    endtask

    task automatic post_alloc(input logic [32:0] size, input logic [31:0] align);
        send_beat(rsba_pkg::OP_ALLOCATE, $urandom, rand64(), rand64(), size, align);
    endtask

    function automatic logic [31:0] pick_type();
        logic [31:0] usable [7];
        usable = '{rsba_pkg::MT_LOADER_CODE, rsba_pkg::MT_LOADER_DATA,
                   rsba_pkg::MT_BOOT_CODE, rsba_pkg::MT_BOOT_DATA,
                   rsba_pkg::MT_CONVENTIONAL, rsba_pkg::MT_ACPI_RECLAIM,
                   rsba_pkg::MT_ACPI_NVS};
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 15);
            1: return $urandom;
            default: return usable[$urandom_range(0, 6)];
        endcase
    endfunction

    function automatic logic [32:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 33'($urandom_range(0, 256));
        else if (roll < 80)
            return 33'($urandom_range(0, 1 << 16));
        else if (roll < 92)
            return 33'($urandom);
        else if (roll < 96)
            return '0;
        else
            return 33'h1_0000_0000;
    endfunction

    function automatic logic [31:0] pick_align();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 32'd1 << $urandom_range(0, 12);
        else if (roll < 75)
            return '0;
        else if (roll < 85)
            return 32'd1 << $urandom_range(13, 31);
        else
            return $urandom_range(0, 32'h8000_0000);
    endfunction

    // One scan-and-allocate round: a few descriptors, usually a finish, then a
    // run of allocations with the odd late descriptor or unused code mixed in.
    // The address span of the well-formed descriptors widens over the run, so
    // the chosen pool keeps getting replaced by longer regions and the top
    // reaches the 4 GiB clamp only in the last part of the run.
    task automatic run_round();
        int          count;
        int          shift;
        logic [63:0] span;
        logic [63:0] start;
        logic [63:0] pages;
        shift = 22 + (sent_items * 12) / ITEM_TARGET;
        span  = 64'd1 << shift;
        count = $urandom_range(1, 4);
        repeat (count) begin
            if ($urandom_range(0, 99) < 85) begin
                start = rand64() & (span - 64'd1);
                if ($urandom_range(0, 1) == 0)
                    start[11:0] = '0;
                pages = rand64() % ((span >> 12) + 64'd1);
                post_descriptor(pick_type(), start, pages);
            end else begin
                post_descriptor($urandom, rand64(), rand64());
            end
        end
        if ($urandom_range(0, 9) != 0)
            post_finish();
        count = $urandom_range(2, 12);
        repeat (count) begin
            case ($urandom_range(0, 19))
                0: post_descriptor(pick_type(), rand64() & (span - 64'd1),
                                   rand64() % ((span >> 12) + 64'd1));
                1: send_beat(OP_UNUSED, $urandom, rand64(), rand64(),
                             33'($urandom), $urandom);
                default: post_alloc(pick_size(), pick_align());
            endcase
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Before any finish the pointer sits at 0 and the limit is 0: an empty
        // request is granted at address 0, a one-byte request is refused.
        post_alloc(33'd0, 32'd0);
        post_alloc(33'd1, 32'd0);
        send_beat(OP_UNUSED, $urandom, rand64(), rand64(), 33'($urandom), $urandom);

        // Unusable type codes are dropped.
        post_descriptor(32'd0, 64'h10_0000, 64'h100);
        post_descriptor(32'hFFFF_FFFF, 64'h10_0000, 64'h100);
        // First usable region becomes the pool; an equally long one does not
        // replace it but still raises the top.
        post_descriptor(rsba_pkg::MT_LOADER_CODE, 64'h1000, 64'h10);
        post_descriptor(rsba_pkg::MT_LOADER_DATA, 64'h20_0000, 64'h10);
        // Empty regions: zero pages, an end that wraps below the start, and a
        // start at the very top of the 64-bit space.
        post_descriptor(rsba_pkg::MT_BOOT_CODE, 64'h30_0000, 64'h0);
        post_descriptor(rsba_pkg::MT_BOOT_DATA, 64'hFFFF_F000, 64'hFFFF_FFFF_FFFF_FFFF);
        post_descriptor(rsba_pkg::MT_ACPI_RECLAIM, 64'hFFFF_FFFF_FFFF_F000, 64'h2);
        // Longer region starting below 1 MiB: the finish lifts its base.
        post_descriptor(rsba_pkg::MT_CONVENTIONAL, 64'h8_0123, 64'h200);
        post_finish();

        // Default alignment, a non-power-of-two alignment, a 4 GiB size and
        // the largest power-of-two alignment.
        post_alloc(33'h10, 32'd0);
        post_alloc(33'd1, 32'd3);
        post_alloc(33'h1_0000_0000, 32'd0);
        post_alloc(33'h40, 32'h8000_0000);

        // A longer region after the finish takes over the pool but leaves the
        // pointer alone, so the next allocation still starts from it.
        post_descriptor(rsba_pkg::MT_ACPI_NVS, 64'h30_0ABC, 64'h300);
        post_alloc(33'h100, 32'h1000);
        // Back-to-back finishes round the unaligned base up to 4 KiB.
        post_finish();
        post_finish();
        // Fill the pool exactly to its limit, then an empty request right at
        // the limit, then one byte too many.
        post_alloc(33'h2F_FABC, 32'h1000);
        post_alloc(33'd0, 32'd1);
        post_alloc(33'd1, 32'd1);
        post_finish();

        while (sent_items < ITEM_TARGET)
            run_round();
        i_in_valid <= 1'b0;

        // Wait for every predicted result, then give the two-stage pipeline a
        // few more cycles so that any stray extra beat is caught.
        @(negedge i_clk);
        while (outstanding != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0) begin
            $display("** region_select_bump_allocator: PASSED **");
        end else begin
            $display("** region_select_bump_allocator: FAILED **");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rsba_pkg.sv
rtl/region_select_bump_allocator.sv
tb/region_select_bump_allocator_checker.sv
tb/tb.sv
